@@ rtl/mmeg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmeg_pkg
// Shared types, constants and the sine lookup for the multi-mode excitation
// generator.
// ----------------------------------------------------------------------------
package mmeg_pkg;

   // Width of every drive code.
   localparam int CODE_W = 12;
   localparam int TICK_W = 16;

   // Default timing and ramp bounds.
   localparam int PRBS_HOLD_DEFAULT   = 8;
   localparam int SQUARE_HALF_DEFAULT = 200;
   localparam int RAMP_LOW_DEFAULT    = 800;
   localparam int RAMP_HIGH_DEFAULT   = 3280;
   localparam int SINE_STEPS_DEFAULT  = 40;

   // Register reset values.
   localparam logic [CODE_W-1:0] LOW_LEVEL_RESET  = 12'd800;
   localparam logic [CODE_W-1:0] HIGH_LEVEL_RESET = 12'd1240;

   // The sine table has a fixed length; its read tap counts modulo this.
   localparam int SINE_TABLE_LEN = 40;
   localparam int SINE_TAP_W     = 6;
   localparam logic [SINE_TAP_W-1:0] SINE_TAP_LAST = 6'(SINE_TABLE_LEN - 1);

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE     = 2'd0,
      CSR_LOW_LEVEL  = 2'd1,
      CSR_HIGH_LEVEL = 2'd2
   } csr_index_type;

   // Item operation codes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_BUTTON = 1'b1;

   // Generator modes, in button order.
   typedef enum logic [1:0] {
      MODE_PRBS   = 2'd0,
      MODE_SQUARE = 2'd1,
      MODE_SINE   = 2'd2,
      MODE_RAMP   = 2'd3
   } mode_type;

   // One period of floor(1020 + 220*sin(2*pi*n/40)).
   function automatic logic [CODE_W-1:0] sine_code(input logic [SINE_TAP_W-1:0] tap);
      logic [CODE_W-1:0] code;
      case (tap)
         6'd0:  code = 12'd1020;
         6'd1:  code = 12'd1054;
         6'd2:  code = 12'd1087;
         6'd3:  code = 12'd1119;
         6'd4:  code = 12'd1149;
         6'd5:  code = 12'd1175;
         6'd6:  code = 12'd1197;
         6'd7:  code = 12'd1216;
         6'd8:  code = 12'd1229;
         6'd9:  code = 12'd1237;
         6'd10: code = 12'd1240;
         6'd11: code = 12'd1237;
         6'd12: code = 12'd1229;
         6'd13: code = 12'd1216;
         6'd14: code = 12'd1197;
         6'd15: code = 12'd1175;
         6'd16: code = 12'd1149;
         6'd17: code = 12'd1119;
         6'd18: code = 12'd1087;
         6'd19: code = 12'd1054;
         6'd20: code = 12'd1020;
         6'd21: code = 12'd985;
         6'd22: code = 12'd952;
         6'd23: code = 12'd920;
         6'd24: code = 12'd890;
         6'd25: code = 12'd864;
         6'd26: code = 12'd842;
         6'd27: code = 12'd823;
         6'd28: code = 12'd810;
         6'd29: code = 12'd802;
         6'd30: code = 12'd800;
         6'd31: code = 12'd802;
         6'd32: code = 12'd810;
         6'd33: code = 12'd823;
         6'd34: code = 12'd842;
         6'd35: code = 12'd864;
         6'd36: code = 12'd890;
         6'd37: code = 12'd920;
         6'd38: code = 12'd952;
         6'd39: code = 12'd985;
         default: code = 12'd0;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/multi_mode_excitation_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_mode_excitation_generator
// PWM excitation source with PRBS, square, sine and triangle ramp modes.
// ----------------------------------------------------------------------------
// Path: a request beat is captured in the input register and its result in the
// result register, which drives rsp_valid; while the result is stalled, the
// item waits in the input register. Throughput: one item per cycle while the
// result is not stalled; the rate is set by the single result register, which
// refills in the cycle its beat is taken. Reset: synchronous, active high; all
// generator state returns to its reset values at once, with no clearing sweep.
module multi_mode_excitation_generator #(
   parameter int PRBS_HOLD   = mmeg_pkg::PRBS_HOLD_DEFAULT,
   parameter int SQUARE_HALF = mmeg_pkg::SQUARE_HALF_DEFAULT,
   parameter int RAMP_LOW    = mmeg_pkg::RAMP_LOW_DEFAULT,
   parameter int RAMP_HIGH   = mmeg_pkg::RAMP_HIGH_DEFAULT,
   parameter int SINE_STEPS  = mmeg_pkg::SINE_STEPS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_operation,
   input  wire logic [mmeg_pkg::TICK_W-1:0]        req_tick_index,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [mmeg_pkg::CODE_W-1:0]             rsp_drive_code,
   output logic [1:0]                              rsp_mode_now,
   // Configuration write channel.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mmeg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mmeg_pkg::CODE_W-1:0]        csr_wdata
);

   localparam int TW     = mmeg_pkg::TICK_W;
   localparam int CW     = mmeg_pkg::CODE_W;
   localparam int STW    = mmeg_pkg::SINE_TAP_W;
   localparam int RECIP_W = 33;
   localparam int PROD_W  = TW + RECIP_W;
   // Reciprocals for exact 16-bit division by a constant: q = (x * M) >> 32.
   localparam logic [RECIP_W-1:0] PRBS_RECIP   =
      RECIP_W'((64'd1 << 32) / PRBS_HOLD + 1);
   localparam logic [RECIP_W-1:0] SQUARE_RECIP =
      RECIP_W'((64'd1 << 32) / SQUARE_HALF + 1);
   localparam int SINE_W = (SINE_STEPS > 1) ? $clog2(SINE_STEPS) : 1;
   localparam logic [SINE_W-1:0] SINE_LAST = SINE_W'(SINE_STEPS - 1);
   localparam logic [CW-1:0] RAMP_LOW_CODE  = CW'(RAMP_LOW);
   localparam logic [CW-1:0] RAMP_HIGH_CODE = CW'(RAMP_HIGH);

   // Configuration registers.
   logic           enable_ff;
   logic [CW-1:0]  low_level_ff;
   logic [CW-1:0]  high_level_ff;

   // Input register.
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_op_ff;
   logic [TW-1:0]  s1_idx_ff;
   logic [TW-1:0]  s1_prbs_q_ff, s1_prbs_q_in;
   logic [TW-1:0]  s1_square_q_ff, s1_square_q_in;

   // Generator state.
   mmeg_pkg::mode_type            mode_ff, mode_in;
   logic [3:0]                    lfsr_ff, lfsr_in;
   logic                          square_ff, square_in;
   logic [SINE_W-1:0]             sine_idx_ff, sine_idx_in;
   logic [STW-1:0]                sine_tap_ff, sine_tap_in;
   logic [CW-1:0]                 ramp_pos_ff, ramp_pos_in;
   logic                          ramp_up_ff, ramp_up_in;
   logic [CW-1:0]                 held_ff, held_in;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]  rsp_code_ff;
   logic [1:0]     rsp_mode_ff;

   logic           out_free;
   logic           s1_load;
   logic           s2_fire;
   logic [PROD_W-1:0] prbs_prod;
   logic [PROD_W-1:0] square_prod;
   logic           prbs_hit;
   logic           square_hit;
   logic           ramp_up_eff;
   logic           lfsr_fb;

   // Handshake: the result register frees up in the cycle its beat is taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_code = rsp_code_ff;
   assign rsp_mode_now   = rsp_mode_ff;

   // Quotients of the tick index, used in the next stage for divisibility.
   assign prbs_prod      = PROD_W'(req_tick_index) * PROD_W'(PRBS_RECIP);
   assign square_prod    = PROD_W'(req_tick_index) * PROD_W'(SQUARE_RECIP);
   assign s1_prbs_q_in   = prbs_prod[32 +: TW];
   assign s1_square_q_in = square_prod[32 +: TW];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // The index is a multiple when quotient times divisor gives it back.
   assign prbs_hit   = (32'(s1_prbs_q_ff) * 32'(PRBS_HOLD)) == 32'(s1_idx_ff);
   assign square_hit = (32'(s1_square_q_ff) * 32'(SQUARE_HALF)) == 32'(s1_idx_ff);

   assign lfsr_fb = lfsr_ff[0] ^ lfsr_ff[1];

   // A position at the high bound turns the ramp down, at the low bound up.
   always_comb begin
      if (ramp_pos_ff == RAMP_HIGH_CODE) begin
         ramp_up_eff = 1'b0;
      end else if (ramp_pos_ff == RAMP_LOW_CODE) begin
         ramp_up_eff = 1'b1;
      end else begin
         ramp_up_eff = ramp_up_ff;
      end
   end

   // Next generator state for the item in the input register.
   always_comb begin
      mode_in     = mode_ff;
      lfsr_in     = lfsr_ff;
      square_in   = square_ff;
      sine_idx_in = sine_idx_ff;
      sine_tap_in = sine_tap_ff;
      ramp_pos_in = ramp_pos_ff;
      ramp_up_in  = ramp_up_ff;
      held_in     = held_ff;
      if (s1_op_ff == mmeg_pkg::OP_BUTTON) begin
         mode_in = mmeg_pkg::mode_type'(mode_ff + 2'd1);
      end else if (enable_ff) begin
         unique case (mode_ff)
            mmeg_pkg::MODE_PRBS: begin
               if (prbs_hit) begin
                  lfsr_in = {lfsr_fb, lfsr_ff[3:1]};
               end
               held_in = lfsr_in[0] ? high_level_ff : low_level_ff;
            end
            mmeg_pkg::MODE_SQUARE: begin
               if (square_hit) begin
                  square_in = !square_ff;
               end
               held_in = square_in ? high_level_ff : low_level_ff;
            end
            mmeg_pkg::MODE_SINE: begin
               held_in = mmeg_pkg::sine_code(sine_tap_ff);
               // The tap follows the index modulo the table length.
               if (sine_idx_ff == SINE_LAST) begin
                  sine_idx_in = '0;
                  sine_tap_in = '0;
               end else begin
                  sine_idx_in = sine_idx_ff + SINE_W'(1);
                  sine_tap_in = (sine_tap_ff == mmeg_pkg::SINE_TAP_LAST) ?
                                '0 : sine_tap_ff + STW'(1);
               end
            end
            mmeg_pkg::MODE_RAMP: begin
               ramp_up_in  = ramp_up_eff;
               ramp_pos_in = ramp_up_eff ? ramp_pos_ff + CW'(1) : ramp_pos_ff - CW'(1);
               held_in     = ramp_pos_in;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         low_level_ff  <= mmeg_pkg::LOW_LEVEL_RESET;
         high_level_ff <= mmeg_pkg::HIGH_LEVEL_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= mmeg_pkg::MODE_PRBS;
         lfsr_ff       <= 4'hF;
         square_ff     <= 1'b0;
         sine_idx_ff   <= '0;
         sine_tap_ff   <= '0;
         ramp_pos_ff   <= RAMP_LOW_CODE;
         ramp_up_ff    <= 1'b1;
         held_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mmeg_pkg::CSR_ENABLE:     enable_ff     <= csr_wdata[0];
               mmeg_pkg::CSR_LOW_LEVEL:  low_level_ff  <= csr_wdata;
               mmeg_pkg::CSR_HIGH_LEVEL: high_level_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (s2_fire) begin
            mode_ff     <= mode_in;
            lfsr_ff     <= lfsr_in;
            square_ff   <= square_in;
            sine_idx_ff <= sine_idx_in;
            sine_tap_ff <= sine_tap_in;
            ramp_pos_ff <= ramp_pos_in;
            ramp_up_ff  <= ramp_up_in;
            held_ff     <= held_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_op_ff       <= req_operation;
         s1_idx_ff      <= req_tick_index;
         s1_prbs_q_ff   <= s1_prbs_q_in;
         s1_square_q_ff <= s1_square_q_in;
      end
      if (s2_fire) begin
         rsp_code_ff <= held_in;
         rsp_mode_ff <= mode_in;
      end
   end

   // A loaded result carries the mode now in force.
   a_mode_matches : assert property (@(posedge clock) disable iff (reset)
      s2_fire |=> (rsp_mode_ff == mode_ff))
      else $error("result mode differs from mode register");

   // A disabled tick repeats the held code.
   a_disabled_holds : assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s1_op_ff == mmeg_pkg::OP_TICK && !enable_ff)
      |=> (rsp_code_ff == $past(held_ff)))
      else $error("disabled tick changed the drive code");

   // A button press advances the mode by one.
   a_button_advances : assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s1_op_ff == mmeg_pkg::OP_BUTTON)
      |=> (mode_ff == 2'($past(mode_ff) + 2'd1)))
      else $error("button did not advance the mode");

   // An item waiting on a blocked result register is not lost.
   a_item_kept : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("pending item dropped while output stalled");

endmodule
`default_nettype wire
